/* rtl/svalloc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the sound voice allocator.
// No dependencies; imported by every module under rtl/.
package svalloc_pkg;

    localparam int ACTIVE_W   = 6;   // active voice count register
    localparam int OWNER_W    = 16;
    localparam int SOUND_W    = 10;
    localparam int PRIO_W     = 8;
    localparam int VOICE_W    = 5;   // voice number on the stream ports
    localparam int KIND_W     = 2;
    localparam int ACTION_W   = 3;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START      = 3'd0,
        ACT_STOP_OWNER = 3'd1,
        ACT_STOP_ALL   = 3'd2,
        ACT_FINISHED   = 3'd3,
        ACT_QUERY      = 3'd4
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FREE  = 2'd0,
        KIND_OWNER = 2'd1,
        KIND_EVICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN_RD,
        ST_FIN_CK,
        ST_DONE
    } state_t;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic [VOICE_W-1:0]  voice_index;
        logic [PRIO_W-1:0]   new_priority;
        logic                match_by_id;
        logic [SOUND_W-1:0]  sound_id;
        logic                has_owner;
        logic [OWNER_W-1:0]  owner_id;
        logic [ACTION_W-1:0] action;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [KIND_W-1:0]  replace_kind;
        logic [VOICE_W-1:0] chosen_voice;
        logic               success;
    } res_t;

    // Payload stored in the voice RAM
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [PRIO_W-1:0]  prio;
        logic [SOUND_W-1:0] sound;
    } voice_entry_t;

    // One registered table read
    typedef struct packed {
        logic         busy;
        logic         owned;
        voice_entry_t entry;
    } voice_rd_t;

    // Compare results for the voice under test
    typedef struct packed {
        logic free;
        logic start_take;
        logic stop_hit;
        logic query_hit;
        logic evict_ok;
    } match_t;

    // Table update strobes from the sequencer
    typedef struct packed {
        logic wr_en;
        logic wr_owned;
        logic kill_en;
        logic clr_en;
    } tbl_ctl_t;

endpackage

/* rtl/svalloc_table.sv */
`timescale 1ns / 1ps
// Voice table: busy/owned flags in flops, owner/priority/sound in a RAM.
// One registered read port, one write/kill port, bulk clear. Uses svalloc_pkg.
module svalloc_table
    import svalloc_pkg::*;
#(
    parameter int NUM_VOICES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [$clog2(NUM_VOICES > 1 ? NUM_VOICES : 2)-1:0] rd_addr,
    output voice_rd_t           rd_data,
    input  tbl_ctl_t            ctl,
    input  logic [$clog2(NUM_VOICES > 1 ? NUM_VOICES : 2)-1:0] op_idx,
    input  voice_entry_t        wr_entry,
    input  logic [$clog2(NUM_VOICES + 1)-1:0] clr_count
);

    localparam int CNT_W = $clog2(NUM_VOICES + 1);

    logic [NUM_VOICES-1:0] busy_reg, busy_next;
    logic [NUM_VOICES-1:0] owned_reg, owned_next;
    voice_entry_t          mem [NUM_VOICES];
    voice_entry_t          rd_entry_reg;
    logic                  rd_busy_reg;
    logic                  rd_owned_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        owned_next = owned_reg;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            if (ctl.clr_en && (CNT_W'(i) < clr_count))
            begin
                busy_next[i]  = 1'b0;
                owned_next[i] = 1'b0;
            end
        end
        if (ctl.kill_en)
        begin
            busy_next[op_idx]  = 1'b0;
            owned_next[op_idx] = 1'b0;
        end
        if (ctl.wr_en)
        begin
            busy_next[op_idx]  = 1'b1;
            owned_next[op_idx] = ctl.wr_owned;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= '0;
            owned_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            owned_reg <= owned_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[op_idx] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
        rd_busy_reg  <= busy_reg[rd_addr];
        rd_owned_reg <= owned_reg[rd_addr];
    end

    assign rd_data = '{busy: rd_busy_reg, owned: rd_owned_reg, entry: rd_entry_reg};

    // an owned voice is always a busy one
    a_owned_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (owned_reg & ~busy_reg) == '0)
        else $error("owned voice not busy");

    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |=> busy_reg[$past(op_idx)])
        else $error("written voice not busy");

endmodule

/* rtl/svalloc_match.sv */
`timescale 1ns / 1ps
// Shared compare unit: checks the voice just read against the request.
// Owner, sound and priority compares. Uses svalloc_pkg.
module svalloc_match
    import svalloc_pkg::*;
(
    input  req_t      req,
    input  voice_rd_t voice,
    output match_t    m
);

    logic owner_eq;
    logic sound_eq;

    assign owner_eq = voice.owned && (voice.entry.owner == req.owner_id);
    assign sound_eq = voice.busy && (voice.entry.sound == req.sound_id);

    assign m.free       = !voice.busy;
    assign m.start_take = !voice.busy || (req.has_owner && owner_eq);
    assign m.stop_hit   = voice.busy && (req.has_owner ? owner_eq : !voice.owned);
    assign m.query_hit  = (req.has_owner && owner_eq) || (req.match_by_id && sound_eq);
    assign m.evict_ok   = voice.entry.prio >= req.new_priority;

endmodule

/* rtl/svalloc_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: walks the voice table one entry per cycle through the compare
// unit and issues table updates. Uses svalloc_pkg.
module svalloc_ctrl
    import svalloc_pkg::*;
#(
    parameter int NUM_VOICES = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  req_t                in_req,
    input  logic [$clog2(NUM_VOICES + 1)-1:0] n_live,
    output req_t                cur_req,
    input  match_t              m,
    output logic [$clog2(NUM_VOICES > 1 ? NUM_VOICES : 2)-1:0] rd_addr,
    output tbl_ctl_t            tbl,
    output logic [$clog2(NUM_VOICES > 1 ? NUM_VOICES : 2)-1:0] op_idx,
    output voice_entry_t        wr_entry,
    output logic [$clog2(NUM_VOICES + 1)-1:0] clr_count,
    output logic                res_valid,
    input  logic                res_take,
    output res_t                res
);

    localparam int IDX_W = $clog2(NUM_VOICES > 1 ? NUM_VOICES : 2);
    localparam int CNT_W = $clog2(NUM_VOICES + 1);
    localparam int CMP_W = (CNT_W > VOICE_W) ? CNT_W : VOICE_W;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               ev_found_reg, ev_found_next;
    logic [IDX_W-1:0]   ev_idx_reg, ev_idx_next;
    res_t               res_reg, res_next;

    logic               accept;
    logic               fin_in_range;
    logic               is_last;
    logic               hit;
    logic               scan_stop;
    logic               evict_end;
    logic [CNT_W-1:0]   rd_idx_cnt;

    assign accept       = in_valid && in_ready;
    assign fin_in_range = CMP_W'(in_req.voice_index) < CMP_W'(n_live);
    assign rd_idx_cnt   = CNT_W'(rd_idx_reg);
    assign is_last      = (rd_idx_cnt + CNT_W'(1)) == n_reg;

    always_comb
    begin
        unique case (req_reg.action)
            ACT_START:      hit = m.start_take;
            ACT_STOP_OWNER: hit = m.stop_hit;
            ACT_QUERY:      hit = m.query_hit;
            default:        hit = 1'b0;
        endcase
    end

    assign scan_stop = rd_vld_reg && (hit || is_last);
    // no free or same-owner voice: take the earliest evictable one
    assign evict_end = (req_reg.action == ACT_START) && !hit && is_last
                       && (ev_found_reg || m.evict_ok);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_req.action)
                        ACT_START, ACT_STOP_OWNER, ACT_QUERY:
                            state_next = (n_live == '0) ? ST_DONE : ST_SCAN;
                        ACT_FINISHED:
                            state_next = fin_in_range ? ST_FIN_RD : ST_DONE;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIN_RD: state_next = ST_FIN_CK;
            ST_FIN_CK: state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        req_next      = req_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        ev_found_next = ev_found_reg;
        ev_idx_next   = ev_idx_reg;
        res_next      = res_reg;
        tbl           = '0;
        tbl.wr_owned  = req_reg.has_owner;
        op_idx        = rd_idx_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next      = in_req;
                    n_next        = n_live;
                    cnt_next      = '0;
                    ev_found_next = 1'b0;
                    res_next      = '0;
                    if (in_req.action == ACT_STOP_ALL)
                    begin
                        tbl.clr_en       = 1'b1;
                        res_next.success = 1'b1;
                    end
                    if (in_req.action == ACT_FINISHED)
                    begin
                        res_next.chosen_voice = in_req.voice_index;
                        if (fin_in_range)
                        begin
                            cnt_next = CNT_W'(in_req.voice_index);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if ((cnt_reg < n_reg) && !scan_stop)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!ev_found_reg && m.evict_ok)
                    begin
                        ev_found_next = 1'b1;
                        ev_idx_next   = rd_idx_reg;
                    end
                    if (hit)
                    begin
                        res_next.success = 1'b1;
                        if (req_reg.action == ACT_START)
                        begin
                            tbl.wr_en             = 1'b1;
                            res_next.chosen_voice = VOICE_W'(rd_idx_reg);
                            res_next.replace_kind = m.free ? KIND_FREE : KIND_OWNER;
                        end
                        else if (req_reg.action == ACT_STOP_OWNER)
                        begin
                            tbl.kill_en           = 1'b1;
                            res_next.chosen_voice = VOICE_W'(rd_idx_reg);
                        end
                    end
                    else if (evict_end)
                    begin
                        op_idx                = ev_found_reg ? ev_idx_reg : rd_idx_reg;
                        tbl.wr_en             = 1'b1;
                        res_next.success      = 1'b1;
                        res_next.chosen_voice = VOICE_W'(op_idx);
                        res_next.replace_kind = KIND_EVICT;
                    end
                end
            end
            ST_FIN_RD:
            begin
            end
            ST_FIN_CK:
            begin
                op_idx = cnt_reg[IDX_W-1:0];
                if (!m.free)
                begin
                    tbl.kill_en      = 1'b1;
                    res_next.success = 1'b1;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign clr_count = n_live;
    assign wr_entry  = '{owner: req_reg.owner_id, prio: req_reg.new_priority,
                         sound: req_reg.sound_id};
    assign cur_req   = req_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            ev_found_reg <= 1'b0;
            cnt_reg      <= '0;
            n_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            ev_found_reg <= ev_found_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_idx_reg <= rd_idx_next;
        ev_idx_reg <= ev_idx_next;
        res_reg    <= res_next;
    end

    a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> state_reg == ST_SCAN)
        else $error("read data valid outside scan");

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (cnt_reg <= n_reg) && (n_reg != '0))
        else $error("scan counter out of range");

    a_wr_kill: assert property (@(posedge clk) disable iff (!rst_n)
        tbl.wr_en |-> !tbl.kill_en && !tbl.clr_en)
        else $error("conflicting table updates");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted transaction not started");

endmodule

/* rtl/sound_voice_allocator.sv */
`timescale 1ns / 1ps
// Top level of the sound voice allocator: stream ports, active count register,
// result register. Uses svalloc_pkg, svalloc_table, svalloc_match, svalloc_ctrl.
//
//  channel  | signals                       | payload
//  ---------+-------------------------------+------------------------------------
//  request  | s_tvalid s_tready s_tdata     | one action on the voice table
//  result   | m_tvalid m_tready m_tdata     | success, voice, replace kind
//  config   | cfg_valid cfg_ready cfg_data  | active voice count (always ready)
//
// Start, stop owner and query walk the table at one voice per cycle through the
// shared compare unit, over the active voices. Voice finished checks a single
// voice; stop all and unknown actions go straight to the result.
// Reset clears the busy and owned marks at once and sets the count to 32.
// A waiting result does not block the next request; a new result waits in the
// sequencer until the result register frees up.
module sound_voice_allocator
    import svalloc_pkg::*;
#(
    parameter int MAX_VOICES = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // action[2:0] owner_id[18:3] has_owner[19] sound_id[29:20] match_by_id[30]
    // new_priority[38:31] voice_index[43:39] zero[47:44]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // success[0] chosen_voice[5:1] replace_kind[7:6]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [ACTIVE_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_VOICES > 1 ? MAX_VOICES : 2);
    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    logic [ACTIVE_W-1:0]  active_reg;
    logic [CNT_W-1:0]     n_live;
    req_t                 in_req;
    req_t                 cur_req;
    voice_rd_t            rd_data;
    match_t               m;
    tbl_ctl_t             tbl;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     op_idx;
    voice_entry_t         wr_entry;
    logic [CNT_W-1:0]     clr_count;
    logic                 res_valid;
    logic                 res_take;
    res_t                 res;
    logic                 m_tvalid_reg;
    res_t                 m_tdata_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_W'(32);
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    // counts above the table size act as the table size
    assign n_live = (CMP_W'(active_reg) > CMP_W'(MAX_VOICES)) ? CNT_W'(MAX_VOICES)
                                                              : CNT_W'(active_reg);

    assign in_req = req_t'(s_tdata[REQ_W-1:0]);

    svalloc_ctrl #(
        .NUM_VOICES (MAX_VOICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .n_live    (n_live),
        .cur_req   (cur_req),
        .m         (m),
        .rd_addr   (rd_addr),
        .tbl       (tbl),
        .op_idx    (op_idx),
        .wr_entry  (wr_entry),
        .clr_count (clr_count),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    svalloc_table #(
        .NUM_VOICES (MAX_VOICES)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .ctl       (tbl),
        .op_idx    (op_idx),
        .wr_entry  (wr_entry),
        .clr_count (clr_count)
    );

    svalloc_match u_match (
        .req   (cur_req),
        .voice (rd_data),
        .m     (m)
    );

    assign res_take = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            m_tdata_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
